// ===== design/acpe_pkg.sv =====
// Shared types, constants and constant tables of the compressed position encoder.
package acpe_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYMBOL_TABLE = 2'd0;
  localparam logic [1:0] CFG_SYMBOL_CODE  = 2'd1;
  localparam logic [1:0] CFG_TYPE_BYTE    = 2'd2;

  // Register reset values
  localparam logic [6:0] SYMBOL_TABLE_RESET = 7'd92;
  localparam logic [6:0] SYMBOL_CODE_RESET  = 7'd94;
  localparam logic [6:0] TYPE_BYTE_RESET    = 7'd91;

  // Characters
  localparam logic [6:0] CHR_OFFSET = 7'd33;
  localparam logic [6:0] CHR_BANG   = 7'd33;
  localparam logic [6:0] CHR_MAX    = 7'd123;

  // Position scaling, 1e-5 degree inputs
  localparam logic signed [25:0] LAT_OFFSET = 26'sd9000000;
  localparam logic signed [26:0] LON_OFFSET = 27'sd18000000;
  localparam logic [18:0] LAT_SCALE = 19'd380926;
  localparam logic [17:0] LON_SCALE = 18'd190463;
  localparam logic [43:0] DIVISOR   = 44'd100000;
  // DIVISOR * 91^4: products at or above this saturate to 91^4-1
  localparam logic [43:0] SAT_LIMIT = 44'd6857496100000;

  localparam logic [8:0] COURSE_MAX = 9'd360;

  // Digit unit: 28 quotient bits, two per step
  localparam int unsigned DIGIT_STEPS = 14;
  localparam logic [3:0]  LAST_STEP   = 4'(DIGIT_STEPS - 1);
  localparam logic [3:0]  SPEED_STEPS = 4'd7;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  typedef logic [43:0] digit_weight_t [28];
  typedef logic [10:0] speed_thr_t [128];

  // Weight of quotient bit i: DIVISOR * 91^(3-digit) * 2^(6-bit), digit-major order
  function automatic digit_weight_t digit_weights();
    digit_weight_t tab;
    logic [43:0]   base;
    base = DIVISOR;
    for (int dg = 3; dg >= 0; dg--) begin
      for (int b = 0; b < 7; b++) begin
        tab[dg * 7 + b] = base << (6 - b);
      end
      base = base * 44'd91;
    end
    return tab;
  endfunction

  // Smallest whole speed reaching 1.08^k, powers truncated at 40 fraction bits
  function automatic speed_thr_t speed_thresholds();
    speed_thr_t  tab;
    logic [63:0] p;
    logic [63:0] c;
    tab[0] = '0;
    p = 64'd1 << 40;
    for (int k = 1; k < 128; k++) begin
      p = p * 64'd27 / 64'd25;
      c = (p + (64'd1 << 40) - 64'd1) >> 40;
      tab[k] = (c > 64'd2047) ? 11'd2047 : c[10:0];
    end
    return tab;
  endfunction

  localparam digit_weight_t DIGIT_WEIGHTS = digit_weights();
  localparam speed_thr_t    SPEED_THR     = speed_thresholds();

  // One classified fix, ready to emit
  typedef struct packed {
    logic [3:0][6:0] lat_chr;
    logic [3:0][6:0] lon_chr;
    logic [6:0]      course_chr;
    logic [6:0]      speed_chr;
  } fix_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ===== design/acpe_front.sv =====
// Front end: takes a fix, scales position, splits base-91 digits, codes course and speed.
module acpe_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [24:0]     latitude,
  input  logic signed [25:0]     longitude,
  input  logic [8:0]             course_deg,
  input  logic [9:0]             speed_knots,
  output logic                   busy,
  input  acpe_pkg::queue_status_t q_status,
  output logic                   push,
  output acpe_pkg::fix_t         push_data
);
  import acpe_pkg::*;

  // two restoring compare-subtract steps
  function automatic logic [45:0] div2(logic [43:0] rem, logic [43:0] w0, logic [43:0] w1);
    logic [43:0] r;
    logic        b0;
    logic        b1;
    b0 = (rem >= w0);
    r  = b0 ? rem - w0 : rem;
    b1 = (r >= w1);
    r  = b1 ? r - w1 : r;
    return {r, b0, b1};
  endfunction

  logic               accept;
  logic               load;
  logic               last_step;
  logic               stall;
  logic signed [25:0] lat_diff;
  logic signed [26:0] lon_sum;
  logic [24:0]        lat_mag;
  logic [25:0]        lon_mag;
  logic [8:0]         cog_clamp;

  // product stage
  logic        stg_valid;
  logic [43:0] stg_lat_n;
  logic [43:0] stg_lon_n;
  logic [6:0]  stg_course;
  logic [9:0]  stg_speed;

  // digit unit
  logic        div_active;
  logic [3:0]  step;
  logic [43:0] lat_rem;
  logic [43:0] lon_rem;
  logic [27:0] lat_quo;
  logic [27:0] lon_quo;
  logic        lat_sat;
  logic        lon_sat;
  logic [6:0]  div_course;
  logic [9:0]  div_speed;
  logic [6:0]  spd_code;

  logic [43:0] w0;
  logic [43:0] w1;
  logic [45:0] lat_step;
  logic [45:0] lon_step;
  logic [27:0] lat_quo_next;
  logic [27:0] lon_quo_next;
  logic [6:0]  spd_cand;
  logic        spd_hit;

  assign last_step = div_active && (step == LAST_STEP);
  assign stall     = last_step && q_status.full;
  assign push      = last_step && !q_status.full;
  assign load      = stg_valid && (!div_active || push);
  assign busy      = stg_valid && !load;
  assign accept    = start && !busy;

  always_comb begin
    lat_diff  = LAT_OFFSET - 26'(latitude);
    lon_sum   = 27'(longitude) + LON_OFFSET;
    lat_mag   = lat_diff[25] ? '0 : lat_diff[24:0];
    lon_mag   = lon_sum[26] ? '0 : lon_sum[25:0];
    cog_clamp = (course_deg > COURSE_MAX) ? COURSE_MAX : course_deg;
  end

  always_comb begin
    w0           = DIGIT_WEIGHTS[{step, 1'b0}];
    w1           = DIGIT_WEIGHTS[{step, 1'b1}];
    lat_step     = div2(lat_rem, w0, w1);
    lon_step     = div2(lon_rem, w0, w1);
    lat_quo_next = {lat_quo[25:0], lat_step[1:0]};
    lon_quo_next = {lon_quo[25:0], lon_step[1:0]};
    // binary search over the power thresholds, one bit per step
    spd_cand     = spd_code | (7'd1 << (3'd6 - step[2:0]));
    spd_hit      = (step < SPEED_STEPS) && (SPEED_THR[spd_cand] <= {1'b0, div_speed});
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      push_data.lat_chr[3 - i] = lat_sat ? CHR_MAX
                                         : lat_quo_next[27 - 7 * i -: 7] + CHR_OFFSET;
      push_data.lon_chr[3 - i] = lon_sat ? CHR_MAX
                                         : lon_quo_next[27 - 7 * i -: 7] + CHR_OFFSET;
    end
    push_data.course_chr = div_course;
    push_data.speed_chr  = spd_code + CHR_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid  <= 1'b0;
      div_active <= 1'b0;
      step       <= '0;
    end else begin
      if (accept) begin
        stg_valid <= 1'b1;
      end else if (load) begin
        stg_valid <= 1'b0;
      end
      if (load) begin
        div_active <= 1'b1;
        step       <= '0;
      end else if (push) begin
        div_active <= 1'b0;
      end else if (div_active && !stall) begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_lat_n  <= LAT_SCALE * lat_mag;
      stg_lon_n  <= LON_SCALE * lon_mag;
      stg_course <= cog_clamp[8:2] + CHR_OFFSET;
      stg_speed  <= speed_knots;
    end
    if (load) begin
      lat_rem    <= stg_lat_n;
      lon_rem    <= stg_lon_n;
      lat_sat    <= (stg_lat_n >= SAT_LIMIT);
      lon_sat    <= (stg_lon_n >= SAT_LIMIT);
      lat_quo    <= '0;
      lon_quo    <= '0;
      div_course <= stg_course;
      div_speed  <= stg_speed;
      spd_code   <= '0;
    end else if (div_active && !stall) begin
      lat_rem <= lat_step[45:2];
      lon_rem <= lon_step[45:2];
      lat_quo <= lat_quo_next;
      lon_quo <= lon_quo_next;
      if (spd_hit) begin
        spd_code <= spd_cand;
      end
    end
  end

endmodule

// ===== design/acpe_queue.sv =====
// Short queue of classified fixes between the front end and the byte emitter.
module acpe_queue #(
  parameter int unsigned DEPTH = acpe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  acpe_pkg::fix_t          push_data,
  input  logic                    pop,
  output acpe_pkg::fix_t          pop_data,
  output acpe_pkg::queue_status_t status
);
  import acpe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fix_t             entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));
  assign pop_data     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/acpe_back.sv =====
// Back end: configuration registers and the fourteen-byte emitter.
module acpe_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [6:0]              cfg_data,
  input  acpe_pkg::queue_status_t q_status,
  input  acpe_pkg::fix_t          q_data,
  output logic                    pop,
  output logic                    result_valid,
  output logic [7:0]              out_byte,
  output logic                    last
);
  import acpe_pkg::*;

  localparam logic [3:0] POS_BANG   = 4'd0;
  localparam logic [3:0] POS_TABLE  = 4'd1;
  localparam logic [3:0] POS_LAT0   = 4'd2;
  localparam logic [3:0] POS_LAT3   = 4'd5;
  localparam logic [3:0] POS_LON0   = 4'd6;
  localparam logic [3:0] POS_LON3   = 4'd9;
  localparam logic [3:0] POS_CODE   = 4'd10;
  localparam logic [3:0] POS_COURSE = 4'd11;
  localparam logic [3:0] POS_SPEED  = 4'd12;
  localparam logic [3:0] POS_LAST   = 4'd13;

  logic [6:0] sym_table;
  logic [6:0] sym_code;
  logic [6:0] type_chr;
  logic       active;
  logic [3:0] pos;
  fix_t       cur;
  logic [6:0] byte_sel;
  logic       at_end;

  assign cfg_ready = 1'b1;
  assign at_end    = (pos == POS_LAST);
  assign pop       = !q_status.empty && (!active || at_end);

  always_comb begin
    case (pos) inside
      POS_BANG:            byte_sel = CHR_BANG;
      POS_TABLE:           byte_sel = sym_table;
      [POS_LAT0:POS_LAT3]: byte_sel = cur.lat_chr[2'(POS_LAT3 - pos)];
      [POS_LON0:POS_LON3]: byte_sel = cur.lon_chr[2'(POS_LON3 - pos)];
      POS_CODE:            byte_sel = sym_code;
      POS_COURSE:          byte_sel = cur.course_chr;
      POS_SPEED:           byte_sel = cur.speed_chr;
      POS_LAST:            byte_sel = type_chr;
      default:             byte_sel = CHR_BANG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_table    <= SYMBOL_TABLE_RESET;
      sym_code     <= SYMBOL_CODE_RESET;
      type_chr     <= TYPE_BYTE_RESET;
      active       <= 1'b0;
      pos          <= '0;
      result_valid <= 1'b0;
      last         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SYMBOL_TABLE: sym_table <= cfg_data;
          CFG_SYMBOL_CODE:  sym_code  <= cfg_data;
          CFG_TYPE_BYTE:    type_chr  <= cfg_data;
          default: ;
        endcase
      end
      if (pop) begin
        active <= 1'b1;
        pos    <= '0;
      end else if (active) begin
        if (at_end) begin
          active <= 1'b0;
        end
        pos <= pos + 4'd1;
      end
      result_valid <= active;
      last         <= active && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    out_byte <= {1'b0, byte_sel};
  end

endmodule

// ===== design/aprs_compressed_position_encoder.sv =====
// Top level of the compressed APRS position body encoder.
//
// A fix (latitude, longitude in 1e-5 degree, course in degrees, speed in
// knots) is taken at a clock edge with start high and busy low. Fourteen
// bytes follow on out_byte, one per cycle with result_valid high and no gaps:
// '!', symbol table, four base-91 latitude digits, four base-91 longitude
// digits, symbol code, course, speed and type; last marks the fourteenth.
// The receiver cannot stall: every strobed byte must be taken. A taken fix
// passes the product stage, the digit unit, the queue and the registered
// byte output before its first byte shows; a fix taken while the previous
// one is still in the digit unit waits in the input stage until loaded.
// Sustained rate is set both by the digit unit (14 radix-4 steps per fix,
// one restoring divider each for latitude and longitude) and by the single
// byte result port; busy is high most of the time at full rate. Out-of-range
// positions saturate to the edge of the base-91 range, courses above 360
// read as 360. Configuration writes (cfg_valid, always ready) are meant for
// idle times only; index 3 is ignored.
module aprs_compressed_position_encoder #(
  parameter int unsigned QUEUE_DEPTH = acpe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // fix input
  input  logic               start,
  output logic               busy,
  input  logic signed [24:0] latitude,
  input  logic signed [25:0] longitude,
  input  logic [8:0]         course_deg,
  input  logic [9:0]         speed_knots,
  // byte output
  output logic               result_valid,
  output logic [7:0]         out_byte,
  output logic               last,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);
  import acpe_pkg::*;

  // front -> queue
  logic          push;
  fix_t          push_data;
  // queue -> back
  logic          pop;
  fix_t          pop_data;
  queue_status_t q_status;

  // Front: product stage plus digit unit; also runs the speed threshold search.
  acpe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .latitude    (latitude),
    .longitude   (longitude),
    .course_deg  (course_deg),
    .speed_knots (speed_knots),
    .busy        (busy),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  // Decouples digit work from byte emission so both run at full rate.
  acpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Back: pops a fix as the previous one finishes, so bursts can run back to back.
  acpe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_status     (q_status),
    .q_data       (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .last         (last)
  );

endmodule

// ===== design/acpe_checker.sv =====
// Port-level checks on the byte bursts of the encoder, bound to the top level.
module acpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic [7:0] out_byte,
  input logic       last
);
  import acpe_pkg::*;

  a_last_strobed: assert property (@(posedge clk) disable iff (rst)
    last |-> result_valid)
    else $error("last without result strobe");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=> result_valid)
    else $error("gap inside a body");

  a_burst_opens: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (!$past(result_valid) || $past(last))) |-> (out_byte == {1'b0, CHR_BANG}))
    else $error("body does not open with bang");

  a_full_length: assert property (@(posedge clk) disable iff (rst)
    last |-> ($past(result_valid, 13) && ($past(out_byte, 13) == {1'b0, CHR_BANG})))
    else $error("body shorter than fourteen bytes");

endmodule

bind aprs_compressed_position_encoder acpe_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the compressed APRS position encoder: directed fixes, then random ones.
module tb;
  import acpe_pkg::*;

  // Index 3 is not mapped; writes to it must leave every register alone.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam longint BASE91_SPAN     = 64'sd68574961;  // 91^4
  localparam int     BODY_BYTES      = 14;
  localparam int     PHASES          = 8;
  localparam int     FIXES_PER_PHASE = 38;
  localparam int     SETTLE_CYCLES   = 24;   // a bit more than the fix-to-first-byte latency

  // Body bytes in emission order: index 0 is the '!' byte.
  typedef logic [0:13][7:0] body_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } body_byte_t;

  // One fix; rows with known set carry their body typed in.
  typedef struct packed {
    logic signed [24:0] lat;
    logic signed [25:0] lon;
    logic [8:0]         course;
    logic [9:0]         speed;
    logic               known;
    body_t              body;
  } fix_row_t;

  // Reset registers: '!', '\', digits, '^', course, speed, type 91.
  // North pole at the date line west, standing still, heading north: all digits zero.
  localparam body_t POLE_BODY =
    {8'd33, 8'd92, {8{8'd33}}, 8'd94, 8'd33, 8'd33, 8'd91};
  // Far south and far east of the range: both positions clamp to 91^4-1, course clamps to 360.
  localparam body_t SAT_BODY =
    {8'd33, 8'd92, {8{8'd123}}, 8'd94, 8'd123, 8'd33, 8'd91};
  // Far north and far west of the range: both positions clamp to zero.
  localparam body_t FLOOR_BODY =
    {8'd33, 8'd92, {8{8'd33}}, 8'd94, 8'd123, 8'd33, 8'd91};

  localparam int DIRECTED_ROWS = 16;
  localparam fix_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{25'sd9000000,   -26'sd18000000, 9'd0,    10'd0,    1'b1, POLE_BODY},
    '{25'sh1000000,   26'sd33554431,  9'd511,  10'd1,    1'b1, SAT_BODY},
    '{25'sd16777215,  26'sh2000000,   9'd360,  10'd0,    1'b1, FLOOR_BODY},
    '{-25'sd9000000,  26'sd18000000,  9'd4,    10'd2,    1'b0, '0},
    '{25'sd0,         26'sd0,         9'd90,   10'd3,    1'b0, '0},
    '{25'sd1,         -26'sd1,        9'd359,  10'd1022, 1'b0, '0},
    '{-25'sd1,        26'sd1,         9'd361,  10'd512,  1'b0, '0},
    '{25'sd4500000,   -26'sd7400000,  9'd180,  10'd1023, 1'b0, '0},
    '{-25'sd3355443,  26'sd12345678,  9'd3,    10'd100,  1'b0, '0},
    '{25'sd8999999,   -26'sd17999999, 9'd1,    10'd255,  1'b0, '0},
    '{-25'sd8999999,  26'sd17999999,  9'd2,    10'd14,   1'b0, '0},
    // just inside and just past the top of the base-91 range
    '{-25'sd9002173,  26'sd18004347,  9'd7,    10'd5,    1'b0, '0},
    '{-25'sd9002174,  26'sd18004348,  9'd8,    10'd6,    1'b0, '0},
    '{25'sd9000001,   -26'sd18000001, 9'd400,  10'd7,    1'b0, '0},
    // alternating bit patterns on every field
    '{25'sh0AAAAAA,   26'sh1555555,   9'h0AA,  10'h2AA,  1'b0, '0},
    '{25'sh1555555,   26'sh2AAAAAA,   9'h155,  10'h155,  1'b0, '0}
  };

  // Register settings of the first random phases, extremes included
  localparam logic [6:0] TABLE_SET [4] = '{7'd0,   7'd127, 7'd33,  7'd126};
  localparam logic [6:0] CODE_SET  [4] = '{7'd127, 7'd0,   7'd126, 7'd33};
  localparam logic [6:0] TYPE_SET  [4] = '{7'd33,  7'd126, 7'd0,   7'd127};

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [24:0] latitude;
  logic signed [25:0] longitude;
  logic [8:0]         course_deg;
  logic [9:0]         speed_knots;
  logic               result_valid;
  logic [7:0]         out_byte;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [6:0]         cfg_data;

  // Our copy of the configuration registers
  logic [6:0] sym_table = SYMBOL_TABLE_RESET;
  logic [6:0] sym_code  = SYMBOL_CODE_RESET;
  logic [6:0] type_chr  = TYPE_BYTE_RESET;

  body_byte_t pending_bytes [$];   // expected bytes, oldest first
  body_byte_t head;
  int         mismatches = 0;

  aprs_compressed_position_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .latitude     (latitude),
    .longitude    (longitude),
    .course_deg   (course_deg),
    .speed_knots  (speed_knots),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Scaled position (before the divide by 1e5) to four base-91 characters.
  // Negative products clamp to zero, oversized ones to 91^4-1.
  function automatic logic [0:3][7:0] base91_digits(input longint product);
    longint          scaled;
    logic [0:3][7:0] d;
    scaled = (product < 0) ? 64'sd0 : product / 64'sd100000;
    if (scaled > BASE91_SPAN - 1) scaled = BASE91_SPAN - 1;
    for (int i = 3; i >= 0; i--) begin
      d[i] = 8'(scaled % 64'sd91 + 64'sd33);
      scaled = scaled / 64'sd91;
    end
    return d;
  endfunction

  // floor(log1.08(speed)) + 33: count powers of 1.08, kept with 40 fraction
  // bits and truncated each step, that do not exceed the speed.
  function automatic logic [7:0] speed_char(input logic [9:0] speed);
    logic [63:0] limit;
    logic [63:0] power;
    int          k;
    if (speed == '0) return 8'd33;
    limit = {54'd0, speed} << 40;
    power = 64'd1 << 40;
    k = 0;
    while (k < 200) begin
      power = power * 64'd27 / 64'd25;
      if (power > limit) break;
      k++;
    end
    return 8'(k + 33);
  endfunction

  // Whole compressed body of one fix under the current register copy
  function automatic body_t encode_body(input logic signed [24:0] lat,
                                        input logic signed [25:0] lon,
                                        input logic [8:0] course,
                                        input logic [9:0] speed);
    body_t      b;
    logic [8:0] crs;
    crs = (course > COURSE_MAX) ? COURSE_MAX : course;
    b[0] = {1'b0, CHR_BANG};
    b[1] = {1'b0, sym_table};
    b[2:5] = base91_digits(longint'(LAT_SCALE) * (64'sd9000000 - longint'(lat)));
    b[6:9] = base91_digits(longint'(LON_SCALE) * (64'sd18000000 + longint'(lon)));
    b[10] = {1'b0, sym_code};
    b[11] = 8'(crs / 9'd4) + 8'd33;
    b[12] = speed_char(speed);
    b[13] = {1'b0, type_chr};
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the fix is
  // taken, with start still high so a back-to-back fix needs no re-raise.
  task automatic send_fix(input fix_row_t f);
    body_t exp_body;
    start       <= 1'b1;
    latitude    <= f.lat;
    longitude   <= f.lon;
    course_deg  <= f.course;
    speed_knots <= f.speed;
    do @(posedge clk); while (busy);
    exp_body = f.known ? f.body : encode_body(f.lat, f.lon, f.course, f.speed);
    for (int i = 0; i < BODY_BYTES; i++) begin
      pending_bytes.push_back('{exp_body[i], 1'(i == BODY_BYTES - 1)});
    end
    @(negedge clk);
  endtask

  // One register write; valid stays up for the caller to drop
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SYMBOL_TABLE: sym_table = val;
      CFG_SYMBOL_CODE:  sym_code  = val;
      CFG_TYPE_BYTE:    type_chr  = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_registers(input logic [6:0] tbl, input logic [6:0] code,
                                   input logic [6:0] kind);
    write_reg(CFG_SYMBOL_TABLE, tbl);
    write_reg(CFG_SYMBOL_CODE, code);
    write_reg(CFG_TYPE_BYTE, kind);
    write_reg(CFG_SPARE, 7'($urandom_range(127)));
    cfg_valid <= 1'b0;
  endtask

  // Drop start and let every expected byte come out, then a short settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_bytes.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Byte checker. The output cannot be stalled, so every strobed byte is
  // taken at the edge that ends its cycle and matched against the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $error("out_byte: expected none, got 8'h%02h", out_byte);
      end else begin
        head = pending_bytes.pop_front();
        if (out_byte !== head.value) begin
          mismatches++;
          $error("out_byte: expected 8'h%02h, got 8'h%02h", head.value, out_byte);
        end
        if (last !== head.last) begin
          mismatches++;
          $error("last: expected %0b, got %0b", head.last, last);
        end
      end
    end
  end

  initial begin : stimulus
    fix_row_t    f;
    logic [31:0] raw;
    int          idle_pct;

    rst         = 1'b1;
    start       = 1'b0;
    latitude    = '0;
    longitude   = '0;
    course_deg  = '0;
    speed_knots = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_SYMBOL_TABLE;
    cfg_data    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed fixes, back to back, registers still at reset
    for (int r = 0; r < DIRECTED_ROWS; r++) send_fix(DIRECTED[r]);

    // Random phases. Each reprograms the registers while idle, then runs
    // with a different gap pattern on the fix side: none, heavy (84%), none
    // again and light (14%). The byte side cannot stall, so the phases that
    // would stall it run like the steady ones.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph < 4)
        program_registers(TABLE_SET[ph], CODE_SET[ph], TYPE_SET[ph]);
      else
        program_registers(7'($urandom_range(127)), 7'($urandom_range(127)),
                          7'($urandom_range(127)));
      case (ph % 4)
        1:       idle_pct = 84;
        3:       idle_pct = 14;
        default: idle_pct = 0;
      endcase

      for (int n = 0; n < FIXES_PER_PHASE; n++) begin
        while ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          @(negedge clk);
        end
        f = '0;
        // Mostly real positions; now and then any bit pattern, which
        // exercises the clamps and the sign bits.
        raw = $urandom();
        if ($urandom_range(99) < 85)
          f.lat = 25'(int'($urandom_range(18000000)) - 9000000);
        else
          f.lat = raw[24:0];
        raw = $urandom();
        if ($urandom_range(99) < 85)
          f.lon = 26'(int'($urandom_range(36000000)) - 18000000);
        else
          f.lon = raw[25:0];
        f.course = ($urandom_range(9) != 0) ? 9'($urandom_range(360))
                                            : 9'($urandom_range(511));
        // low speeds are where the log steps are densest
        case ($urandom_range(3))
          0:       f.speed = 10'($urandom_range(3));
          1:       f.speed = 10'($urandom_range(40));
          default: f.speed = 10'($urandom_range(1023));
        endcase
        send_fix(f);
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard limit, far above the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/acpe_pkg.sv
design/acpe_front.sv
design/acpe_queue.sv
design/acpe_back.sv
design/aprs_compressed_position_encoder.sv
design/acpe_checker.sv
tb/tb.sv
